// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent assertions on a clock with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/mklm_pkg.sv =====
// ----------------------------------------------------------------------------
// mklm_pkg
// Constants, types and helpers shared by the keyword line matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package mklm_pkg;

	localparam int NUM_KEYS    = 8;
	localparam int MAX_KEY_LEN = 16;
	localparam int MAX_LINE    = 256;

	localparam int OP_W     = 3;
	localparam int SLOT_W   = 3;
	localparam int POS_W    = 4;
	localparam int BYTE_W   = 8;
	localparam int ACT_W    = 4;
	localparam int MASK_W   = 8;

	localparam int LEN_W    = $clog2(MAX_KEY_LEN + 1);
	localparam int IDX_W    = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
	localparam int LINE_W   = $clog2(MAX_LINE + 1);
	localparam int ROW_W    = MAX_KEY_LEN * BYTE_W;
	localparam int RAM_AW   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	typedef enum logic [OP_W-1:0] {
		OP_KEY_BYTE = 3'd0,
		OP_KEY_LEN  = 3'd1,
		OP_TEXT     = 3'd2,
		OP_EOL      = 3'd3,
		OP_CLEAR    = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_KEY_WR
	} state_t;

	typedef logic [BYTE_W-1:0] byte_t;

	// Byte 0 of a keyword row is the first keyword byte; byte 0 of the
	// history is the newest text byte.
	typedef logic [MAX_KEY_LEN-1:0][BYTE_W-1:0] row_t;
	typedef logic [MAX_KEY_LEN-1:0][BYTE_W-1:0] hist_t;

	typedef struct packed {
		logic [LEN_W-1:0]  key_len;
		logic [LINE_W-1:0] line_len;
	} cmp_req_t;

	function automatic byte_t fold_lower(input byte_t b);
		byte_t c;
		c = b;
		if (b inside {[8'h41:8'h5A]}) begin
			c = b + 8'h20;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mklm_ram.sv =====
// ----------------------------------------------------------------------------
// mklm_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mklm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mklm_window_cmp.sv =====
// ----------------------------------------------------------------------------
// mklm_window_cmp
// Compares one keyword row against the newest bytes of the text history.
// ----------------------------------------------------------------------------
`default_nettype none

module mklm_window_cmp (
	input  wire mklm_pkg::row_t     row,
	input  wire mklm_pkg::hist_t    hist,
	input  wire mklm_pkg::cmp_req_t req,
	output logic                    hit
);

	logic same;

	// Keyword byte i lines up with the text byte len-1-i places back.
	always_comb begin
		logic [mklm_pkg::LEN_W-1:0] idx;
		same = 1'b1;
		idx  = '0;
		for (int i = 0; i < mklm_pkg::MAX_KEY_LEN; i++) begin
			if (mklm_pkg::LEN_W'(i) < req.key_len) begin
				idx = req.key_len - mklm_pkg::LEN_W'(i) - mklm_pkg::LEN_W'(1);
				if (row[i] != hist[idx[mklm_pkg::IDX_W-1:0]]) begin
					same = 1'b0;
				end
			end
		end
	end

	assign hit = (req.key_len != '0) && (int'(req.key_len) <= int'(req.line_len)) && same;

endmodule

`default_nettype wire

// ===== hw/rtl/multi_keyword_line_matcher.sv =====
// ----------------------------------------------------------------------------
// multi_keyword_line_matcher
// Case-insensitive search of text lines for up to eight stored keywords.
// ----------------------------------------------------------------------------
// Keywords sit one to a row in a small RAM and are folded to lower case as
// they are loaded. A text byte is taken in its transfer and then scanned
// with one step per keyword slot, in which a shared window comparator checks
// one RAM row against the history while the next row is read. A keyword byte
// is written as a read-modify-write of its row; keyword lengths, end of
// line and clearing the found flags act on transfer. End of line loads the
// result register, and the next item is taken while that result waits,
// but a further end of line waits until the held result is transferred.
`default_nettype none

module multi_keyword_line_matcher (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_wr_en,
	input  wire logic [3:0]  cfg_wr_data,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  operation,
	input  wire logic [2:0]  key_slot,
	input  wire logic [3:0]  key_position,
	input  wire logic [7:0]  value,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             line_matched,
	output logic [7:0]       line_hits,
	output logic [7:0]       found_flags,
	output logic             status
);

	localparam int NK  = mklm_pkg::NUM_KEYS;
	localparam int AW  = mklm_pkg::RAM_AW;
	localparam int MW  = mklm_pkg::MASK_W;

	mklm_pkg::state_t state_q, state_d;
	mklm_pkg::op_t    op;

	logic [AW-1:0]                 scan_cnt_q;
	mklm_pkg::hist_t               hist_q;
	logic [mklm_pkg::LINE_W-1:0]   line_len_q;
	logic [MW-1:0]                 line_hit_q;
	logic [MW-1:0]                 found_q;
	logic [mklm_pkg::LEN_W-1:0]    key_len_q [NK];
	logic [NK-1:0]                 row_valid_q;
	logic [mklm_pkg::ACT_W-1:0]    active_q;

	logic [AW-1:0]                 kslot_q;
	logic [mklm_pkg::IDX_W-1:0]    kpos_q;
	mklm_pkg::byte_t               kbyte_q;

	logic                          out_valid_q;
	logic                          line_matched_q;
	logic [MW-1:0]                 line_hits_q;
	logic [MW-1:0]                 found_flags_q;
	logic                          status_q;

	logic in_xfer, slot_ok, pos_ok;
	logic do_kbyte, do_klen, do_text, do_eol, do_clear;
	logic scan_last;

	logic [AW-1:0]              rd_addr, rd_slot;
	logic [mklm_pkg::ROW_W-1:0] rd_data;
	mklm_pkg::row_t             row_rd, row_new;
	mklm_pkg::cmp_req_t         cmp_req;
	logic                       cmp_hit;

	logic [mklm_pkg::ACT_W-1:0] n_act;
	logic [MW-1:0]              act_mask, empty_mask, eol_hits;
	logic                       line_ok, eol_status;
	mklm_pkg::byte_t            text_byte;
	logic [mklm_pkg::LEN_W-1:0] len_sat;

	assign op       = mklm_pkg::op_t'(operation);
	assign in_stall = (state_q != mklm_pkg::ST_IDLE) ||
		((op == mklm_pkg::OP_EOL) && out_valid_q && out_stall);
	assign in_xfer  = in_valid && !in_stall;
	assign slot_ok  = int'(key_slot) < NK;
	assign pos_ok   = int'(key_position) < mklm_pkg::MAX_KEY_LEN;

	always_comb begin
		do_kbyte = 1'b0;
		do_klen  = 1'b0;
		do_text  = 1'b0;
		do_eol   = 1'b0;
		do_clear = 1'b0;
		case (op)
			mklm_pkg::OP_KEY_BYTE: do_kbyte = in_xfer && slot_ok && pos_ok;
			mklm_pkg::OP_KEY_LEN:  do_klen  = in_xfer && slot_ok;
			mklm_pkg::OP_TEXT:     do_text  = in_xfer;
			mklm_pkg::OP_EOL:      do_eol   = in_xfer;
			mklm_pkg::OP_CLEAR:    do_clear = in_xfer;
			default: ;
		endcase
	end

	assign scan_last = (scan_cnt_q == AW'(NK - 1));

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mklm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mklm_pkg::ST_IDLE: begin
				if (do_text) begin
					state_d = mklm_pkg::ST_SCAN;
				end else if (do_kbyte) begin
					state_d = mklm_pkg::ST_KEY_WR;
				end
			end
			mklm_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_d = mklm_pkg::ST_IDLE;
				end
			end
			mklm_pkg::ST_KEY_WR: state_d = mklm_pkg::ST_IDLE;
			default:             state_d = mklm_pkg::ST_IDLE;
		endcase
	end

	// Row 0 is read during the text transfer, so each scan cycle compares the
	// row that arrived and fetches the next one.
	always_comb begin
		if (state_q == mklm_pkg::ST_SCAN) begin
			rd_addr = scan_cnt_q + AW'(1);
		end else if (op == mklm_pkg::OP_KEY_BYTE) begin
			rd_addr = AW'(key_slot);
		end else begin
			rd_addr = '0;
		end
	end

	assign rd_slot = (state_q == mklm_pkg::ST_SCAN) ? scan_cnt_q : kslot_q;
	assign row_rd  = row_valid_q[rd_slot] ? mklm_pkg::row_t'(rd_data) : '0;

	always_comb begin
		row_new         = row_rd;
		row_new[kpos_q] = kbyte_q;
	end

	mklm_ram #(
		.WIDTH(mklm_pkg::ROW_W),
		.DEPTH(NK)
	) u_key_ram (
		.clk    (clk),
		.wr_en  (state_q == mklm_pkg::ST_KEY_WR),
		.wr_addr(kslot_q),
		.wr_data(mklm_pkg::ROW_W'(row_new)),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign cmp_req.key_len  = key_len_q[scan_cnt_q];
	assign cmp_req.line_len = line_len_q;

	mklm_window_cmp u_cmp (
		.row (row_rd),
		.hist(hist_q),
		.req (cmp_req),
		.hit (cmp_hit)
	);

	// End of line report
	always_comb begin
		n_act      = (int'(active_q) > NK) ? mklm_pkg::ACT_W'(NK) : active_q;
		act_mask   = '0;
		empty_mask = '0;
		for (int s = 0; s < NK; s++) begin
			act_mask[s]   = mklm_pkg::ACT_W'(s) < n_act;
			empty_mask[s] = (key_len_q[s] == '0);
		end
		eol_status = line_len_q >= mklm_pkg::LINE_W'(mklm_pkg::MAX_LINE);
		line_ok    = (line_len_q != '0) && !eol_status;
		eol_hits   = line_ok ? ((line_hit_q | empty_mask) & act_mask) : '0;
	end

	assign text_byte = mklm_pkg::fold_lower(value);
	assign len_sat   = (int'(value) > mklm_pkg::MAX_KEY_LEN) ?
		mklm_pkg::LEN_W'(mklm_pkg::MAX_KEY_LEN) : mklm_pkg::LEN_W'(value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q  <= '0;
			hist_q      <= '0;
			line_len_q  <= '0;
			line_hit_q  <= '0;
			found_q     <= '0;
			row_valid_q <= '0;
			active_q    <= mklm_pkg::ACT_W'(1);
			out_valid_q <= 1'b0;
			for (int s = 0; s < NK; s++) begin
				key_len_q[s] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				active_q <= cfg_wr_data;
			end

			if (state_q == mklm_pkg::ST_SCAN) begin
				scan_cnt_q <= scan_last ? '0 : scan_cnt_q + AW'(1);
				if (cmp_hit) begin
					line_hit_q[scan_cnt_q] <= 1'b1;
				end
			end

			if (state_q == mklm_pkg::ST_KEY_WR) begin
				row_valid_q[kslot_q] <= 1'b1;
			end

			if (do_klen) begin
				key_len_q[AW'(key_slot)] <= len_sat;
			end

			if (do_text) begin
				for (int i = mklm_pkg::MAX_KEY_LEN - 1; i > 0; i--) begin
					hist_q[i] <= hist_q[i-1];
				end
				hist_q[0] <= text_byte;
				if (line_len_q < mklm_pkg::LINE_W'(mklm_pkg::MAX_LINE)) begin
					line_len_q <= line_len_q + mklm_pkg::LINE_W'(1);
				end
			end

			if (do_clear) begin
				found_q <= '0;
			end

			// A held result stays until transferred; an end of line reloads it.
			out_valid_q <= do_eol || (out_valid_q && out_stall);

			if (do_eol) begin
				found_q     <= found_q | eol_hits;
				hist_q      <= '0;
				line_len_q  <= '0;
				line_hit_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_kbyte) begin
			kslot_q <= AW'(key_slot);
			kpos_q  <= mklm_pkg::IDX_W'(key_position);
			kbyte_q <= text_byte;
		end
		if (do_eol) begin
			line_matched_q <= (eol_hits != '0);
			line_hits_q    <= eol_hits;
			found_flags_q  <= found_q | eol_hits;
			status_q       <= eol_status;
		end
	end

	assign out_valid    = out_valid_q;
	assign line_matched = line_matched_q;
	assign line_hits    = line_hits_q;
	assign found_flags  = found_flags_q;
	assign status       = status_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mklm_checker.sv =====
// ----------------------------------------------------------------------------
// mklm_checker
// Port-level checks on the keyword line matcher, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mklm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [2:0] operation,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       line_matched,
	input wire logic [7:0] line_hits,
	input wire logic [7:0] found_flags,
	input wire logic       status
);

	logic eol_xfer;

	assign eol_xfer = in_valid && !in_stall &&
		(operation == mklm_pkg::OP_EOL);

	// A result stays offered until it is transferred.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// A new result appears only after an end of line transfer.
	`ASSERT_IMPL(a_out_cause, clk, arst_n, $rose(out_valid), $past(eol_xfer))

	`ASSERT_IMPL(a_matched_hits, clk, arst_n, out_valid, line_matched == (line_hits != 8'h00))

	// A rejected line reports no hits.
	`ASSERT_IMPL(a_long_no_hits, clk, arst_n, out_valid && status, line_hits == 8'h00)

	// Every hit of a line is already folded into the sticky flags.
	`ASSERT_IMPL(a_hits_in_found, clk, arst_n, out_valid, (line_hits & ~found_flags) == 8'h00)

endmodule

bind multi_keyword_line_matcher mklm_checker u_mklm_checker (.*);

`default_nettype wire
